@@ hw/rtl/slins_pkg.sv @@
// Shared codes and types for the sorted list insert unit.
package slins_pkg;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Per-cell control, driven by the top level each cycle.
	typedef struct packed {
		logic ins;   // commit an insert this cycle
		logic valid; // cell holds a live entry
		logic sel;   // cell addressed by a read
	} cell_ctl_t;

endpackage

@@ hw/rtl/slins_cell.sv @@
// One storage cell of the sorted list: compare, hold or shift.
module slins_cell import slins_pkg::*; #(
	parameter int W        = 16,
	parameter int IDX_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic signed [W-1:0] value,
	input  logic signed [W-1:0] left_entry,
	input  logic                left_le,
	output logic signed [W-1:0] entry,
	output logic                le,
	output logic [IDX_W-1:0]    pos_term,
	output logic [W-1:0]        rd_term
);

	logic signed [W-1:0] entry_q;
	logic                slot;

	// live entries are kept in order, so le forms a run of ones from cell 0
	assign le    = ctl.valid && (entry_q <= value);
	assign slot  = !le && left_le;
	assign entry = entry_q;

	assign pos_term = slot ? IDX_W'(CELL_IDX) : '0;
	assign rd_term  = ctl.sel ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins && !le) begin
			entry_q <= left_le ? value : left_entry;
		end
	end

endmodule

@@ hw/rtl/sorted_list_insert_unit.sv @@
// Top level of the sorted list insert unit: cell chain, count and result register.
//
// Holds up to CAPACITY signed entries in ascending order in a row of cells. In a transaction,
// all cells compare against the incoming value at once and those above the insert slot take
// their lower neighbour's entry on the same edge, while a read selects one cell by index.
// A new item is accepted every cycle as long as the result register is empty or being
// drained; the result appears in the cycle after acceptance. Inserts into a full list
// leave it unchanged and set error; reads at or beyond the count return zero with error set.
// The list is empty after reset.
module sorted_list_insert_unit import slins_pkg::*; #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 16,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic [IDX_W-1:0]              index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] read_value,
	output logic [IDX_W-1:0]              position,
	output logic [CNT_W-1:0]              entry_count,
	output logic                          error
);

	logic [CNT_W-1:0]             cnt_q;
	logic                         out_valid_q;
	logic signed [VALUE_WIDTH-1:0] read_value_q;
	logic [IDX_W-1:0]             position_q;
	logic [CNT_W-1:0]             entry_count_q;
	logic                         error_q;

	logic                         in_acc;
	logic                         full;
	logic                         do_ins;
	logic                         rd_err;

	logic signed [VALUE_WIDTH-1:0] entry_w [CAPACITY];
	logic [CAPACITY-1:0]           le_w;
	logic [IDX_W-1:0]              pos_w   [CAPACITY];
	logic [VALUE_WIDTH-1:0]        rd_w    [CAPACITY];
	cell_ctl_t                     ctl_w   [CAPACITY];

	logic [IDX_W-1:0]              pos_or;
	logic [VALUE_WIDTH-1:0]        rd_or;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign full     = (cnt_q == CNT_W'(CAPACITY));
	assign do_ins   = in_acc && (func == FUNC_INSERT) && !full;
	assign rd_err   = (CNT_W'(index) >= cnt_q);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctl_w[i].ins   = do_ins;
		assign ctl_w[i].valid = (cnt_q > CNT_W'(i));
		assign ctl_w[i].sel   = (index == IDX_W'(i));

		if (i == 0) begin : g_first
			slins_cell #(.W(VALUE_WIDTH), .IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
				.clk        (clk),
				.ctl        (ctl_w[i]),
				.value      (value),
				.left_entry (value),
				.left_le    (1'b1),
				.entry      (entry_w[i]),
				.le         (le_w[i]),
				.pos_term   (pos_w[i]),
				.rd_term    (rd_w[i])
			);
		end else begin : g_rest
			slins_cell #(.W(VALUE_WIDTH), .IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
				.clk        (clk),
				.ctl        (ctl_w[i]),
				.value      (value),
				.left_entry (entry_w[i-1]),
				.left_le    (le_w[i-1]),
				.entry      (entry_w[i]),
				.le         (le_w[i]),
				.pos_term   (pos_w[i]),
				.rd_term    (rd_w[i])
			);
		end
	end

	// at most one cell flags the slot and at most one is selected, so OR is a mux
	always_comb begin
		pos_or = '0;
		rd_or  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pos_or = pos_or | pos_w[i];
			rd_or  = rd_or | rd_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (func == FUNC_INSERT) begin
				read_value_q  <= '0;
				position_q    <= full ? '0 : pos_or;
				entry_count_q <= full ? cnt_q : cnt_q + CNT_W'(1);
				error_q       <= full;
			end else begin
				read_value_q  <= rd_err ? '0 : $signed(rd_or);
				position_q    <= '0;
				entry_count_q <= cnt_q;
				error_q       <= rd_err;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;
	assign error       = error_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not advance the count");

	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) |-> entry_w[0] <= entry_w[1])
		else $error("lowest cells out of order");

	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && func == FUNC_INSERT && full |=> out_valid_q && error_q && position_q == '0)
		else $error("insert into full list not flagged");

endmodule
